FILE: rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg: shared types and constants of the roi dwell run encoder
// sample, hit and run transaction types, config indexes and sizing
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

  localparam int unsigned TuplesPerPacket = 8;
  localparam int unsigned RegionSlots     = 6;
  localparam int unsigned CoordBits       = 12;
  localparam int unsigned TableEntries    = 6;
  localparam int unsigned SlotBits        = 6;
  localparam int unsigned HitDepth        = 4;
  localparam int unsigned HitPtrBits      = 2;
  localparam int unsigned OutDepth        = 2;

  localparam logic [11:0] CoordMask      = 12'((32'd1 << CoordBits) - 32'd1);
  localparam logic [15:0] TimeStepReset  = 16'd10;
  localparam logic [2:0]  RegionLimit    = 3'(RegionSlots);

  typedef enum logic [2:0] {
    CfgTimeStep    = 3'd0,
    CfgRegionCount = 3'd1,
    CfgRegion0     = 3'd2,
    CfgRegion1     = 3'd3,
    CfgRegion2     = 3'd4,
    CfgRegion3     = 3'd5,
    CfgRegion4     = 3'd6,
    CfgRegion5     = 3'd7
  } rde_cfg_idx_e;

  typedef struct packed {
    logic [11:0] gaze_x;
    logic [11:0] gaze_y;
  } rde_in_t;

  typedef struct packed {
    logic [7:0]  run_region;
    logic [31:0] run_start_time;
    logic [31:0] run_end_time;
    logic        packet_end;
  } rde_out_t;

  // one region table entry, same layout as the config word
  typedef struct packed {
    logic [7:0]  id;
    logic [11:0] x0;
    logic [11:0] y0;
    logic [11:0] x1;
    logic [11:0] y1;
  } rde_region_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic [7:0]  region;
    logic [31:0] stamp;
  } rde_hit_t;

endpackage

`default_nettype wire

FILE: rtl/roi_dwell_run_encoder.sv
// path: a closing sample is queued as a hit, then its run is written to the result buffer
// throughput: one sample, one hit-queue entry and one run-tracker update per cycle while not
// backpressured; the 4-entry hit queue and 2-entry result buffer absorb short output stalls
// reset: async active low; run state, time counter, queues and config return to defaults
// ----------------------------------------------------------------------------
// roi_dwell_run_encoder: gaze sample to dwell run encoder, top level
// classifies samples against a region table and emits closed dwell runs
// ----------------------------------------------------------------------------
`default_nettype none

module roi_dwell_run_encoder (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // config write port, index follows the register list
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [55:0]       cfg_wdata_i,
  // sample side, queue-like
  input  wire logic              push,
  output logic                   full,
  input  wire rde_pkg::rde_in_t  in_i,
  // result side, queue-like
  output logic                   empty,
  input  wire logic              pop,
  output rde_pkg::rde_out_t      out_o
);

  logic              hit_valid;
  rde_pkg::rde_hit_t hit_wr;
  rde_pkg::rde_hit_t hit_rd;
  logic              hit_empty;
  logic              hit_pop;

  // front: time counter and first-match region search on every sample transaction;
  // samples outside all regions only advance time and are not queued
  rde_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .full_i      (full),
    .in_i        (in_i),
    .hit_valid_o (hit_valid),
    .hit_o       (hit_wr)
  );

  // decoupling queue, its full flag is the sample-side backpressure
  rde_hit_fifo u_hit_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (hit_valid),
    .wr_data_i (hit_wr),
    .full_o    (full),
    .rd_en_i   (hit_pop),
    .empty_o   (hit_empty),
    .rd_data_o (hit_rd)
  );

  // back: run merge, packet slot count and result buffer
  rde_run_tracker u_run_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hit_empty_i (hit_empty),
    .hit_i       (hit_rd),
    .hit_pop_o   (hit_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/rde_classify.sv
// ----------------------------------------------------------------------------
// rde_classify: sample front end
// holds config, keeps the time counter and finds the first region hit
// ----------------------------------------------------------------------------
`default_nettype none

module rde_classify (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [55:0]         cfg_wdata_i,
  input  wire logic                push_i,
  input  wire logic                full_i,
  input  wire rde_pkg::rde_in_t    in_i,
  output logic                     hit_valid_o,
  output rde_pkg::rde_hit_t        hit_o
);

  logic [15:0]         time_step_q;
  logic [2:0]          region_count_q;
  rde_pkg::rde_region_t region_q [rde_pkg::TableEntries];
  logic [31:0]         time_now_q, time_now_d;

  logic                accept;
  logic                found;
  logic [7:0]          found_id;
  logic [11:0]         x, y;
  logic [2:0]          limit;

  assign accept = push_i && !full_i;
  assign x      = in_i.gaze_x & rde_pkg::CoordMask;
  assign y      = in_i.gaze_y & rde_pkg::CoordMask;
  assign limit  = (region_count_q > rde_pkg::RegionLimit) ? rde_pkg::RegionLimit
                                                          : region_count_q;

  // priority search, lowest table index wins
  always_comb begin
    found    = 1'b0;
    found_id = 8'd0;
    for (int i = rde_pkg::TableEntries - 1; i >= 0; i--) begin
      if ((3'(i) < limit) &&
          (x >= (region_q[i].x0 & rde_pkg::CoordMask)) &&
          (x <= (region_q[i].x1 & rde_pkg::CoordMask)) &&
          (y >= (region_q[i].y0 & rde_pkg::CoordMask)) &&
          (y <= (region_q[i].y1 & rde_pkg::CoordMask))) begin
        found    = 1'b1;
        found_id = region_q[i].id;
      end
    end
  end

  assign time_now_d   = time_now_q + {16'd0, time_step_q};
  assign hit_valid_o  = accept && found;
  assign hit_o.region = found_id;
  assign hit_o.stamp  = time_now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q <= 32'd0;
    end else if (accept) begin
      time_now_q <= time_now_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q    <= rde_pkg::TimeStepReset;
      region_count_q <= 3'd0;
      for (int i = 0; i < rde_pkg::TableEntries; i++) begin
        region_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (rde_pkg::rde_cfg_idx_e'(cfg_idx_i))
        rde_pkg::CfgTimeStep:    time_step_q    <= cfg_wdata_i[15:0];
        rde_pkg::CfgRegionCount: region_count_q <= cfg_wdata_i[2:0];
        default: begin
          region_q[cfg_idx_i - 3'(rde_pkg::CfgRegion0)] <= cfg_wdata_i;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rde_hit_fifo.sv
// ----------------------------------------------------------------------------
// rde_hit_fifo: queue between front and back
// short fifo of classified hits so each side stalls on its own
// ----------------------------------------------------------------------------
`default_nettype none

module rde_hit_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire rde_pkg::rde_hit_t wr_data_i,
  output logic                   full_o,
  input  wire logic              rd_en_i,
  output logic                   empty_o,
  output rde_pkg::rde_hit_t      rd_data_o
);

  rde_pkg::rde_hit_t mem_q [rde_pkg::HitDepth];
  logic [rde_pkg::HitPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [rde_pkg::HitPtrBits:0]   cnt_q, cnt_d;
  logic                           do_wr, do_rd;

  assign full_o    = (cnt_q == (rde_pkg::HitPtrBits+1)'(rde_pkg::HitDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rde_run_tracker.sv
// ----------------------------------------------------------------------------
// rde_run_tracker: run back end
// merges hits into dwell runs and buffers closed runs for the consumer
// ----------------------------------------------------------------------------
`default_nettype none

module rde_run_tracker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              hit_empty_i,
  input  wire rde_pkg::rde_hit_t hit_i,
  output logic                   hit_pop_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output rde_pkg::rde_out_t      out_o
);

  logic [7:0]                  open_region_q, open_region_d;
  logic [31:0]                 open_start_q, open_start_d;
  logic [31:0]                 open_end_q, open_end_d;
  logic [rde_pkg::SlotBits-1:0] slot_q, slot_d;

  rde_pkg::rde_out_t out_mem_q [rde_pkg::OutDepth];
  logic              out_wr_ptr_q, out_rd_ptr_q;
  logic [1:0]        out_cnt_q, out_cnt_d;
  logic              out_rd, out_space, emit, last;
  rde_pkg::rde_out_t tuple;

  assign empty_o   = (out_cnt_q == 2'd0);
  assign out_rd    = pop_i && !empty_o;
  assign out_space = (out_cnt_q != 2'(rde_pkg::OutDepth)) || out_rd;
  assign hit_pop_o = !hit_empty_i && out_space;
  assign out_o     = out_mem_q[out_rd_ptr_q];

  // a hit on another region closes the open run
  assign emit = hit_pop_o && (open_region_q != 8'd0) && (open_region_q != hit_i.region);
  assign last = ({1'b0, slot_q} + 7'd1) >= 7'(rde_pkg::TuplesPerPacket);

  assign tuple.run_region     = open_region_q;
  assign tuple.run_start_time = open_start_q;
  assign tuple.run_end_time   = open_end_q;
  assign tuple.packet_end     = last;

  always_comb begin
    open_region_d = open_region_q;
    open_start_d  = open_start_q;
    open_end_d    = open_end_q;
    slot_d        = slot_q;
    if (hit_pop_o) begin
      if (open_region_q == hit_i.region) begin
        open_end_d = hit_i.stamp;
      end else begin
        open_region_d = hit_i.region;
        open_start_d  = hit_i.stamp;
        open_end_d    = hit_i.stamp;
      end
    end
    if (emit) begin
      slot_d = last ? '0 : slot_q + 1'b1;
    end
  end

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (emit && !out_rd) begin
      out_cnt_d = out_cnt_q + 2'd1;
    end else if (out_rd && !emit) begin
      out_cnt_d = out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_region_q <= 8'd0;
      slot_q        <= '0;
      out_wr_ptr_q  <= 1'b0;
      out_rd_ptr_q  <= 1'b0;
      out_cnt_q     <= 2'd0;
    end else begin
      open_region_q <= open_region_d;
      slot_q        <= slot_d;
      out_cnt_q     <= out_cnt_d;
      if (emit) begin
        out_wr_ptr_q <= ~out_wr_ptr_q;
      end
      if (out_rd) begin
        out_rd_ptr_q <= ~out_rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    open_start_q <= open_start_d;
    open_end_q   <= open_end_d;
    if (emit) begin
      out_mem_q[out_wr_ptr_q] <= tuple;
    end
  end

endmodule

`default_nettype wire
